>>> rtl/b64d_pkg.sv
`timescale 1ns / 1ps
// shared types, constants and the character table of the base64 stream decoder
// no dependencies
package b64d_pkg;

	localparam logic [7:0] PAD_CHAR    = 8'h3D;
	localparam logic [5:0] SEXTET_62   = 6'd62;
	localparam logic [5:0] SEXTET_63   = 6'd63;
	localparam logic [7:0] BYTE_MASK   = 8'hFF;
	localparam int         FIFO_DEPTH  = 4;
	localparam int         FIFO_AW     = 2;
	localparam int         PADDR_W     = 2;
	localparam int         TOTAL_W     = 16;
	localparam logic [PADDR_W-1:0] ADDR_MAX_OUTPUT = 2'd0;
	localparam logic [15:0] MAX_OUTPUT_RESET = 16'hFFFF;

	// one decoded group: up to three bytes, how many of them count, and end of string
	typedef struct packed {
		logic [7:0] b0;
		logic [7:0] b1;
		logic [7:0] b2;
		logic [1:0] cnt;
		logic       last;
	} b64d_entry_t;

	function automatic logic [5:0] sextet_of(input logic [7:0] c);
		logic [5:0] s;
		s = 6'd0;
		if (c >= 8'h41 && c <= 8'h5A) begin
			s = 6'(c - 8'h41);
		end else if (c >= 8'h61 && c <= 8'h7A) begin
			s = 6'(c - 8'h61 + 8'd26);
		end else if (c >= 8'h30 && c <= 8'h39) begin
			s = 6'(c - 8'h30 + 8'd52);
		end else if (c == 8'h2B || c == 8'h2D || c == 8'h2E) begin
			s = SEXTET_62;
		end else if (c == 8'h2C || c == 8'h2F || c == 8'h5F) begin
			s = SEXTET_63;
		end
		return s;
	endfunction

endpackage

>>> rtl/b64d_if.sv
`timescale 1ns / 1ps
// channel interfaces of the base64 stream decoder: characters in, bytes out
// no dependencies
interface b64d_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_in;
	logic       is_last;
	modport source(output valid, char_in, is_last, input ready);
	modport sink(input valid, char_in, is_last, output ready);
endinterface

interface b64d_out_if;
	logic        valid;
	logic        ready;
	logic [7:0]  byte_out;
	logic        byte_valid;
	logic        end_of_run;
	logic        overflow;
	logic [15:0] total_length;
	modport source(output valid, byte_out, byte_valid, end_of_run, overflow, total_length,
		input ready);
	modport sink(input valid, byte_out, byte_valid, end_of_run, overflow, total_length,
		output ready);
endinterface

>>> rtl/b64d_front.sv
`timescale 1ns / 1ps
// front end: takes characters, maps them to sextets and packs groups of bytes
// depends on b64d_pkg and b64d_in_if
module b64d_front (
	input  logic                 clk,
	input  logic                 arst_n,
	b64d_in_if.sink              din,
	input  logic                 full,
	output logic                 push,
	output b64d_pkg::b64d_entry_t entry
);

	logic [17:0] acc_q;
	logic [1:0]  pos_q;
	logic        pad3_q;
	logic [23:0] acc24;
	logic [23:0] n;
	logic        is_pad;
	logic        take;
	logic [1:0]  cnt;

	assign din.ready = !full;
	assign take      = din.valid && !full;
	assign is_pad    = (din.char_in == b64d_pkg::PAD_CHAR);
	assign acc24     = {acc_q, b64d_pkg::sextet_of(din.char_in)};

	// left-align the open group so missing sextets read as zero
	always_comb begin
		case (pos_q)
			2'd0:    n = {acc24[5:0], 18'd0};
			2'd1:    n = {acc24[11:0], 12'd0};
			2'd2:    n = {acc24[17:0], 6'd0};
			default: n = acc24;
		endcase
	end

	always_comb begin
		cnt = 2'd0;
		if (!din.is_last) begin
			if (pos_q == 2'd3) cnt = 2'd3;
		end else begin
			case (pos_q)
				2'd3:    cnt = !is_pad ? 2'd3 : (!pad3_q ? 2'd2 : 2'd1);
				2'd2:    cnt = !is_pad ? 2'd2 : 2'd1;
				default: cnt = 2'd1;
			endcase
		end
	end

	assign push       = take && (cnt != 2'd0);
	assign entry.b0   = n[23:16] & b64d_pkg::BYTE_MASK;
	assign entry.b1   = n[15:8];
	assign entry.b2   = n[7:0];
	assign entry.cnt  = cnt;
	assign entry.last = din.is_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q  <= '0;
			pos_q  <= '0;
			pad3_q <= 1'b0;
		end else if (take) begin
			if (din.is_last || pos_q == 2'd3) begin
				acc_q  <= '0;
				pos_q  <= '0;
				pad3_q <= 1'b0;
			end else begin
				if (pos_q == 2'd2) pad3_q <= is_pad;
				acc_q <= acc24[17:0];
				pos_q <= pos_q + 2'd1;
			end
		end
	end

endmodule

>>> rtl/b64d_fifo.sv
`timescale 1ns / 1ps
// short queue of decoded groups between front and back end
// depends on b64d_pkg
module b64d_fifo (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  b64d_pkg::b64d_entry_t wdata,
	output logic                  full,
	input  logic                  pop,
	output b64d_pkg::b64d_entry_t rdata,
	output logic                  empty
);

	b64d_pkg::b64d_entry_t        mem_q [b64d_pkg::FIFO_DEPTH];
	logic [b64d_pkg::FIFO_AW-1:0] wptr_q;
	logic [b64d_pkg::FIFO_AW-1:0] rptr_q;
	logic [b64d_pkg::FIFO_AW:0]   fill_q;

	assign full  = (fill_q == (b64d_pkg::FIFO_AW+1)'(b64d_pkg::FIFO_DEPTH));
	assign empty = (fill_q == '0);
	assign rdata = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wptr_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			fill_q <= '0;
		end else begin
			if (push) wptr_q <= wptr_q + 1'b1;
			if (pop)  rptr_q <= rptr_q + 1'b1;
			case ({push, pop})
				2'b10:   fill_q <= fill_q + 1'b1;
				2'b01:   fill_q <= fill_q - 1'b1;
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule

>>> rtl/b64d_back.sv
`timescale 1ns / 1ps
// back end: sends queued bytes one per cycle while the output is ready, counts them and flags overflow
// depends on b64d_pkg and b64d_out_if
module b64d_back #(
	parameter int COUNT_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [15:0]           max_output,
	input  b64d_pkg::b64d_entry_t head,
	input  logic                  empty,
	output logic                  pop,
	b64d_out_if.source            dout
);

	localparam int CW = (COUNT_BITS > b64d_pkg::TOTAL_W) ? COUNT_BITS : b64d_pkg::TOTAL_W;
	localparam logic [COUNT_BITS-1:0] CMAX = {COUNT_BITS{1'b1}};

	logic [COUNT_BITS-1:0] count_q;
	logic                  ovf_q;
	logic [1:0]            idx_q;
	logic                  out_valid_q;
	logic [7:0]            byte_q;
	logic                  bvalid_q;
	logic                  eor_q;
	logic                  ovf_out_q;
	logic [15:0]           total_q;

	logic                  load;
	logic [7:0]            sel_byte;
	logic                  last_byte;
	logic                  ok;
	logic [COUNT_BITS-1:0] count_next;
	logic                  ovf_next;
	logic                  fin;
	logic [CW-1:0]         count_ext;

	assign load      = !empty && (!out_valid_q || dout.ready);
	assign last_byte = (idx_q == head.cnt - 2'd1);
	assign pop       = load && last_byte;
	assign fin       = head.last && last_byte;

	always_comb begin
		case (idx_q)
			2'd0:    sel_byte = head.b0;
			2'd1:    sel_byte = head.b1;
			default: sel_byte = head.b2;
		endcase
	end

	// a byte is marked valid only while the count stays under the limit and the counter width
	assign ok         = (CW'(count_q) < CW'(max_output)) && (count_q != CMAX);
	assign count_next = ok ? count_q + 1'b1 : count_q;
	assign ovf_next   = ovf_q | !ok;
	assign count_ext  = CW'(count_next);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			ovf_q       <= 1'b0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				count_q     <= fin ? '0 : count_next;
				ovf_q       <= fin ? 1'b0 : ovf_next;
				idx_q       <= last_byte ? 2'd0 : idx_q + 2'd1;
				out_valid_q <= 1'b1;
			end else if (dout.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			byte_q    <= ok ? sel_byte : 8'd0;
			bvalid_q  <= ok;
			eor_q     <= fin;
			ovf_out_q <= fin && ovf_next;
			total_q   <= (fin && !ovf_next) ? count_ext[15:0] : 16'd0;
		end
	end

	assign dout.valid        = out_valid_q;
	assign dout.byte_out     = byte_q;
	assign dout.byte_valid   = bvalid_q;
	assign dout.end_of_run   = eor_q;
	assign dout.overflow     = ovf_out_q;
	assign dout.total_length = total_q;

endmodule

>>> rtl/base64_stream_decoder_core.sv
`timescale 1ns / 1ps
// top level of the base64 stream decoder: register port, front end, queue, back end
// depends on b64d_pkg, b64d_if, b64d_front, b64d_fifo and b64d_back
// Takes one character per cycle while the queue is not full and sends decoded
// bytes one per cycle while the output is ready; a group of four characters
// gives three bytes. The front end packs each group as its last character is
// taken; the back end emits one byte a cycle from a four-entry queue, and that
// single output port sets the byte rate. Each byte passes the queue and the
// output register. Each output transaction carries one byte; the final one of
// a string has end_of_run set with the overflow flag and total length. Bytes past
// max_output (register at address 0, reset 65535) come out with byte_valid low.
module base64_stream_decoder_core #(
	parameter int COUNT_BITS = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [b64d_pkg::PADDR_W-1:0]   paddr,
	input  logic [31:0]                    pwdata,
	output logic [31:0]                    prdata,
	output logic                           pready,
	b64d_in_if.sink                        din,
	b64d_out_if.source                     dout
);

	logic [15:0]           max_output_q;
	logic                  full;
	logic                  empty;
	logic                  push;
	logic                  pop;
	b64d_pkg::b64d_entry_t wentry;
	b64d_pkg::b64d_entry_t head;

	assign pready = 1'b1;
	assign prdata = (paddr == b64d_pkg::ADDR_MAX_OUTPUT) ? {16'd0, max_output_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_output_q <= b64d_pkg::MAX_OUTPUT_RESET;
		end else if (psel && penable && pwrite && paddr == b64d_pkg::ADDR_MAX_OUTPUT) begin
			max_output_q <= pwdata[15:0];
		end
	end

	b64d_front u_front (
		.clk   (clk),
		.arst_n(arst_n),
		.din   (din),
		.full  (full),
		.push  (push),
		.entry (wentry)
	);

	b64d_fifo u_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.wdata (wentry),
		.full  (full),
		.pop   (pop),
		.rdata (head),
		.empty (empty)
	);

	b64d_back #(
		.COUNT_BITS(COUNT_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.max_output(max_output_q),
		.head      (head),
		.empty     (empty),
		.pop       (pop),
		.dout      (dout)
	);

endmodule
